// File: rtl/kdpw_pkg.sv
// Shared types and constants of the kd-tree path code walker.
package kdpw_pkg;

  localparam int CoordBits = 32;
  localparam int IndexBits = 10;
  localparam int LinkBits  = 11;
  localparam int CodeBits  = 32;
  localparam int LevelBits = 6;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    logic                        command;
    logic [IndexBits-1:0]        node_index;
    logic signed [CoordBits-1:0] split_value;
    logic [LinkBits-1:0]         low_child;
    logic [LinkBits-1:0]         high_child;
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [CodeBits-1:0]  path_code;
    logic [LevelBits-1:0] levels_walked;
    logic                 truncated;
  } out_item_t;

  // One stored tree node.
  typedef struct packed {
    logic signed [CoordBits-1:0] split;
    logic [LinkBits-1:0]         low_link;
    logic [LinkBits-1:0]         high_link;
  } node_t;

  // A classified job handed from the front end to the walker.
  typedef struct packed {
    op_e                         op;
    logic [IndexBits-1:0]        index;
    node_t                       node;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } job_t;

endpackage

// File: rtl/kdpw_front.sv
// Front end of the walker: accepts transactions, classifies them and queues the jobs.
module kdpw_front #(
  parameter int NODES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kdpw_pkg::in_item_t in_data_i,
  output logic               job_valid_o,
  output kdpw_pkg::job_t     job_o,
  input  logic               job_pop_i
);

  localparam logic [31:0] NodesW = 32'(NODES);

  kdpw_pkg::job_t queue_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           accept;
  logic           push;
  logic           keep;
  kdpw_pkg::job_t job_new;

  assign in_stall_o = (count_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;

  // Writes to a slot beyond the table are dropped here and never reach the walker.
  always_comb begin
    job_new.index     = in_data_i.node_index;
    job_new.node      = '{split:     in_data_i.split_value,
                          low_link:  in_data_i.low_child,
                          high_link: in_data_i.high_child};
    job_new.x         = in_data_i.point_x;
    job_new.y         = in_data_i.point_y;
    if (in_data_i.command == kdpw_pkg::CmdQuery) begin
      job_new.op = kdpw_pkg::OP_QUERY;
      keep       = 1'b1;
    end else begin
      job_new.op = kdpw_pkg::OP_WRITE;
      keep       = (32'(in_data_i.node_index) < NodesW);
    end
  end

  assign push = accept && keep;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (job_pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !job_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && job_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= job_new;
    end
  end

  assign job_valid_o = (count_q != 2'd0);
  assign job_o       = queue_q[rd_ptr_q];

endmodule

// File: rtl/kdpw_walker.sv
// Back end of the walker: node table, level-by-level tree walk and result register.
module kdpw_walker #(
  parameter int NODES      = 1024,
  parameter int MAX_LEVELS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  kdpw_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kdpw_pkg::out_item_t out_data_o
);

  localparam int          IW      = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [31:0] NodesW  = 32'(NODES);
  localparam logic [kdpw_pkg::LevelBits-1:0] LevelCap = kdpw_pkg::LevelBits'(MAX_LEVELS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  kdpw_pkg::node_t node_mem [NODES];
  kdpw_pkg::node_t rd_q;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   wr_addr;
  logic            mem_we;

  logic signed [kdpw_pkg::CoordBits-1:0] px_q, px_d;
  logic signed [kdpw_pkg::CoordBits-1:0] py_q, py_d;
  logic [kdpw_pkg::CodeBits-1:0]         code_q, code_d;
  logic [kdpw_pkg::LevelBits-1:0]        level_q, level_d;
  logic                                  trunc_q, trunc_d;

  logic signed [kdpw_pkg::CoordBits-1:0] coord;
  logic                                  go_low;
  logic [kdpw_pkg::LinkBits-1:0]         next_link;
  logic                                  at_end;
  logic [IW+kdpw_pkg::LinkBits-1:0]      link_wide;
  logic [IW+kdpw_pkg::IndexBits-1:0]     index_wide;

  logic                out_load;
  logic                out_valid_q, out_valid_d;
  kdpw_pkg::out_item_t out_q;

  // Compare and link selection of the current level.
  always_comb begin
    coord      = level_q[0] ? py_q : px_q;
    go_low     = (coord < rd_q.split);
    next_link  = go_low ? rd_q.low_link : rd_q.high_link;
    at_end     = (32'(next_link) >= NodesW);
    link_wide  = {{IW{1'b0}}, next_link};
    index_wide = {{IW{1'b0}}, job_i.index};
    wr_addr    = index_wide[IW-1:0];
  end

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = '0;
    px_d      = px_q;
    py_d      = py_q;
    code_d    = code_q;
    level_d   = level_q;
    trunc_d   = trunc_q;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          if (job_i.op == kdpw_pkg::OP_QUERY) begin
            // The root is read now, so the first compare follows next cycle.
            px_d    = job_i.x;
            py_d    = job_i.y;
            code_d  = '0;
            level_d = '0;
            state_d = S_WALK;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (go_low) begin
          code_d = code_q | (kdpw_pkg::CodeBits'(1) << level_q[4:0]);
        end
        level_d = level_q + kdpw_pkg::LevelBits'(1);
        rd_addr = link_wide[IW-1:0];
        if (at_end || (level_d == LevelCap)) begin
          trunc_d = !at_end;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    code_q  <= code_d;
    level_q <= level_d;
    trunc_q <= trunc_d;
    if (out_load) begin
      out_q <= '{path_code: code_q, levels_walked: level_q, truncated: trunc_q};
    end
  end

  // Node table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem[wr_addr] <= job_i.node;
    end
    rd_q <= node_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/kd_tree_path_code_walker_core.sv
// Top level of the kd-tree path code walker: front end, job queue and tree walker.
// A point transaction passes the job queue, is popped in S_IDLE while the root is read,
// then walks one tree level per S_WALK step, up to MAX_LEVELS levels, and its result is
// loaded into the output register in S_EMIT once that register is free. A node write holds
// the walker only in S_IDLE; a point holds it until its result is loaded.
// Reset clears the queue, the walker state and the result valid flag; the node table is not
// cleared and holds undefined contents until its nodes are written.
module kd_tree_path_code_walker_core #(
  parameter int NODES      = 1024,
  parameter int MAX_LEVELS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kdpw_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kdpw_pkg::out_item_t out_data_o
);

  // The front end takes each input transaction, turns it into a job and places it in a
  // two-entry queue. Writes aimed beyond the node table are discarded at this point.
  // Because the queue sits between the two halves, a new transaction can be accepted
  // while the walker is still busy with an earlier point or waiting on the output.
  logic           job_valid;
  logic           job_pop;
  kdpw_pkg::job_t job;

  kdpw_front #(
    .NODES (NODES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // The walker takes jobs strictly in order, so a node write placed after a point
  // transaction only takes effect once that walk is over. Each level reads one node
  // from the table and compares the x or y coordinate with its split value; the
  // finished result lands in an output register, which frees the walker to pick up
  // the next job while the result still waits to be taken downstream.
  kdpw_walker #(
    .NODES      (NODES),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
